>>> hw/rtl/mfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfb_pkg;

  // Widths of the transaction fields.
  localparam int OP_W   = 2;
  localparam int X_W    = 7;
  localparam int Y_W    = 8;
  localparam int RW_W   = 8;
  localparam int RH_W   = 9;
  localparam int IDX_W  = 12;
  localparam int BYTE_W = 8;

  // Exclusive span ends: x + width and y + height both fit in ten bits.
  localparam int END_W = 10;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_INVERT = 1'b0;

  // Operation codes on the input channel.
  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // What the back end has to do for one queued command.
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_SPAN = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               white;
    logic [X_W-1:0]     x_pos;
    logic [END_W-1:0]   x_end;
    logic [Y_W-1:0]     y_pos;
    logic [END_W-1:0]   y_end;
    logic [IDX_W-1:0]   rd_idx;
    logic               oor;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_CLEAR  = 3'd0,
    BK_IDLE   = 3'd1,
    BK_ROW    = 3'd2,
    BK_RD     = 3'd3,
    BK_WR     = 3'd4,
    BK_RESULT = 3'd5
  } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mfb_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one drawing or read transaction.
interface mfb_in_if;
  import mfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [X_W-1:0]    x_coord;
  logic [Y_W-1:0]    y_coord;
  logic              pixel_white;
  logic [RW_W-1:0]   rect_width;
  logic [RH_W-1:0]   rect_height;
  logic [IDX_W-1:0]  read_index;

  modport source (
    output valid, operation, x_coord, y_coord, pixel_white, rect_width, rect_height,
           read_index,
    input  ready
  );

  modport sink (
    input  valid, operation, x_coord, y_coord, pixel_white, rect_width, rect_height,
           read_index,
    output ready
  );
endinterface

// Result channel: one result per input transaction.
interface mfb_out_if;
  import mfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              out_of_range;

  modport source (
    output valid, read_byte, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, read_byte, out_of_range,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/mfb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mfb_front #(
  parameter int CANVAS_WIDTH  = 128,
  parameter int CANVAS_HEIGHT = 250
) (
  mfb_in_if.sink          in_chan,
  input  logic            clear_busy,
  output logic            push_valid,
  input  logic            push_ready,
  output mfb_pkg::cmd_t   push_cmd
);
  import mfb_pkg::*;

  localparam int STORE_BYTES = (CANVAS_WIDTH * CANVAS_HEIGHT + 7) / 8;

  logic [END_W-1:0] x_sum;
  logic [END_W-1:0] y_sum;
  logic [END_W-1:0] x_clip;
  logic [END_W-1:0] y_clip;

  // Nothing is taken while the canvas is being cleared after reset.
  assign in_chan.ready = push_ready && !clear_busy;
  assign push_valid    = in_chan.valid && !clear_busy;

  // Rectangle edges, clipped to the canvas.
  assign x_sum  = END_W'(in_chan.x_coord) + END_W'(in_chan.rect_width);
  assign y_sum  = END_W'(in_chan.y_coord) + END_W'(in_chan.rect_height);
  assign x_clip = (int'(x_sum) > CANVAS_WIDTH)  ? END_W'(CANVAS_WIDTH)  : x_sum;
  assign y_clip = (int'(y_sum) > CANVAS_HEIGHT) ? END_W'(CANVAS_HEIGHT) : y_sum;

  // Classify the transaction. A pixel write becomes a one by one span, and anything
  // that touches no memory at all is reduced to a bare result.
  always_comb begin
    push_cmd        = '0;
    push_cmd.kind   = CMD_NONE;
    push_cmd.x_pos  = in_chan.x_coord;
    push_cmd.y_pos  = in_chan.y_coord;
    push_cmd.rd_idx = in_chan.read_index;
    unique case (in_chan.operation)
      OP_PIXEL: begin
        if (int'(in_chan.x_coord) >= CANVAS_WIDTH ||
            int'(in_chan.y_coord) >= CANVAS_HEIGHT) begin
          push_cmd.oor = 1'b1;
        end else begin
          push_cmd.kind  = CMD_SPAN;
          push_cmd.white = in_chan.pixel_white;
          push_cmd.x_end = END_W'(in_chan.x_coord) + END_W'(1);
          push_cmd.y_end = END_W'(in_chan.y_coord) + END_W'(1);
        end
      end
      OP_FILL: begin
        if (x_clip > END_W'(in_chan.x_coord) && y_clip > END_W'(in_chan.y_coord)) begin
          push_cmd.kind  = CMD_SPAN;
          push_cmd.white = 1'b1;
          push_cmd.x_end = x_clip;
          push_cmd.y_end = y_clip;
        end
      end
      OP_READ: begin
        if (int'(in_chan.read_index) >= STORE_BYTES) begin
          push_cmd.oor = 1'b1;
        end else begin
          push_cmd.kind = CMD_READ;
        end
      end
      default: begin
        push_cmd.kind = CMD_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/mfb_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mfb_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mfb_pkg::cmd_t   push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mfb_pkg::cmd_t   pop_cmd
);
  import mfb_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int CNT_W = 2;

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mfb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mfb_back #(
  parameter int CANVAS_WIDTH  = 128,
  parameter int CANVAS_HEIGHT = 250
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  mfb_pkg::cmd_t   cmd,
  input  logic            invert,
  output logic            clear_busy,
  mfb_out_if.source       out_chan
);
  import mfb_pkg::*;

  localparam int PIXELS      = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int STORE_BYTES = (PIXELS + 7) / 8;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PIX_W       = $clog2(PIXELS + 1);

  // Bits of one byte covered by the span, most significant bit first.
  function automatic logic [BYTE_W-1:0] span_mask(input logic first, input logic last,
                                                  input logic [2:0] lo, input logic [2:0] hi);
    logic [BYTE_W-1:0] m;
    m = '0;
    for (int p = 0; p < BYTE_W; p++) begin
      m[BYTE_W-1-p] = (!first || 3'(p) >= lo) && (!last || 3'(p) <= hi);
    end
    return m;
  endfunction

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [ADDR_W-1:0] clr_r;

  cmd_kind_t         kind_r;
  logic              white_r;
  logic [X_W-1:0]    x_r;
  logic [END_W-1:0]  x_end_r;
  logic [END_W-1:0]  row_r;
  logic [END_W-1:0]  y_end_r;
  logic              oor_r;
  logic [PIX_W-1:0]  row_base_r;
  logic [ADDR_W-1:0] byte_r;
  logic [ADDR_W-1:0] last_r;
  logic [2:0]        lo_r;
  logic [2:0]        hi_r;
  logic              first_r;

  logic [BYTE_W-1:0] mem_r [STORE_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_oor_r;

  logic [PIX_W-1:0]  n_start;
  logic [PIX_W-1:0]  n_last;
  logic              byte_last;
  logic              row_last;
  logic              clear_last;
  logic              out_free;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] new_byte;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [BYTE_W-1:0] mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic              out_load;

  // Span geometry for the current row and byte.
  assign n_start    = row_base_r + PIX_W'(x_r);
  assign n_last     = row_base_r + PIX_W'(x_end_r) - PIX_W'(1);
  assign byte_last  = (byte_r == last_r);
  assign row_last   = ((row_r + END_W'(1)) == y_end_r);
  assign clear_last = (clr_r == ADDR_W'(STORE_BYTES - 1));
  assign out_free   = !out_valid_r || out_chan.ready;
  assign mask       = span_mask(first_r, byte_last, lo_r, hi_r);
  assign new_byte   = white_r ? (rd_data_r | mask) : (rd_data_r & ~mask);
  assign clear_busy = (state_r == BK_CLEAR);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: begin
        if (clear_last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = (cmd.kind == CMD_SPAN) ? BK_ROW : BK_RESULT;
        end
      end
      BK_ROW: begin
        state_nxt = BK_RD;
      end
      BK_RD: begin
        state_nxt = BK_WR;
      end
      BK_WR: begin
        if (!byte_last) begin
          state_nxt = BK_RD;
        end else if (row_last) begin
          state_nxt = BK_RESULT;
        end else begin
          state_nxt = BK_ROW;
        end
      end
      BK_RESULT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  // Memory port and handshake controls.
  always_comb begin
    cmd_ready = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
      end
      BK_IDLE: begin
        cmd_ready = 1'b1;
        mem_re    = cmd_valid && (cmd.kind == CMD_READ);
        mem_ra    = ADDR_W'(cmd.rd_idx);
      end
      BK_ROW: begin
        mem_re = 1'b0;
      end
      BK_RD: begin
        mem_re = 1'b1;
        mem_ra = byte_r;
      end
      BK_WR: begin
        mem_we = 1'b1;
        mem_wa = byte_r;
        mem_wd = new_byte;
      end
      BK_RESULT: begin
        out_load = out_free;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command capture and span walking.
  always_ff @(posedge clk) begin
    if (state_r == BK_IDLE && cmd_valid) begin
      kind_r     <= cmd.kind;
      white_r    <= cmd.white;
      x_r        <= cmd.x_pos;
      x_end_r    <= cmd.x_end;
      y_end_r    <= cmd.y_end;
      oor_r      <= cmd.oor;
      row_r      <= END_W'(cmd.y_pos);
      row_base_r <= PIX_W'(int'(cmd.y_pos) * CANVAS_WIDTH);
    end
    if (state_r == BK_ROW) begin
      byte_r  <= ADDR_W'(n_start >> 3);
      last_r  <= ADDR_W'(n_last >> 3);
      lo_r    <= n_start[2:0];
      hi_r    <= n_last[2:0];
      first_r <= 1'b1;
    end
    if (state_r == BK_WR) begin
      if (!byte_last) begin
        byte_r  <= byte_r + ADDR_W'(1);
        first_r <= 1'b0;
      end else if (!row_last) begin
        row_r      <= row_r + END_W'(1);
        row_base_r <= row_base_r + PIX_W'(CANVAS_WIDTH);
      end
    end
  end

  // Canvas memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_ra];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= (kind_r == CMD_READ) ? (rd_data_r ^ {BYTE_W{invert}}) : '0;
      out_oor_r  <= oor_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.read_byte    = out_byte_r;
  assign out_chan.out_of_range = out_oor_r;

endmodule

`default_nettype wire

>>> hw/rtl/mono_framebuffer_pixel_rect_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// One-bit-per-pixel canvas of CANVAS_WIDTH by CANVAS_HEIGHT pixels, packed row-major
// and most significant bit first into a single-port byte RAM. After reset the core
// clears the canvas to black one byte at a time (4000 bytes at the default size)
// and takes no transaction until that is done. A front end classifies and clips
// each transaction and places it in a two-entry command queue; the back end carries
// commands out one at a time against the RAM. Every touched byte is a
// read-modify-write on the RAM port: a pixel write or fill walks each clipped row,
// setting up the row and then reading and writing each byte it touches, before the
// result is sent. Reads and transactions that touch no memory go straight to the
// result. The invert register affects only bytes returned by reads.
module mono_framebuffer_pixel_rect_engine_core #(
  parameter int CANVAS_WIDTH  = 128,
  parameter int CANVAS_HEIGHT = 250
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mfb_in_if.sink                                in_chan,
  mfb_out_if.source                             out_chan,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [mfb_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);
  import mfb_pkg::*;

  logic                 invert_r;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 clear_busy;
  logic                 push_valid;
  logic                 push_ready;
  cmd_t                 push_cmd;
  logic                 pop_valid;
  logic                 pop_ready;
  cmd_t                 pop_cmd;

  // Configuration register access.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_idx == REG_INVERT) ? {31'b0, invert_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_write && cfg_idx == REG_INVERT) begin
      invert_r <= cfg_pwdata[0];
    end
  end

  // Front end: classification and clipping.
  mfb_front #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_front (
    .in_chan    (in_chan),
    .clear_busy (clear_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Command queue between the two halves.
  mfb_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Back end: canvas memory and span sequencer.
  mfb_back #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (pop_valid),
    .cmd_ready  (pop_ready),
    .cmd        (pop_cmd),
    .invert     (invert_r),
    .clear_busy (clear_busy),
    .out_chan   (out_chan)
  );

  // The clearing pass starts from every reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> clear_busy)
    else $error("canvas clearing did not start after reset");

  // No transaction is taken while the canvas is being cleared.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !(in_chan.valid && in_chan.ready))
    else $error("transaction accepted during canvas clearing");

  // An out-of-range result never carries canvas data.
  a_oor_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.out_of_range |-> out_chan.read_byte == '0)
    else $error("out-of-range result with non-zero byte");

endmodule

`default_nettype wire
